/* rtl/core/ect_pkg.sv */
package ect_pkg;

	// Fixed field widths of the stream words and the register port.
	localparam int ADDR_W      = 64;
	localparam int OP_W        = 3;
	localparam int INDEX_OUT_W = 16;
	localparam int COUNT_W     = 8;
	localparam int CFG_IDX_W   = 4;
	localparam int RANGES_W    = 2;

	// Thread filter value after reset and after a new iteration.
	localparam logic [ADDR_W-1:0] FILTER_RESET = 64'h00ff_ffff_ffff_ffff;

	// Operation codes carried in the input tuser.
	localparam logic [OP_W-1:0] OP_BLOCK     = 3'd0;
	localparam logic [OP_W-1:0] OP_CANCEL    = 3'd1;
	localparam logic [OP_W-1:0] OP_INTERRUPT = 3'd2;
	localparam logic [OP_W-1:0] OP_NEW_ITER  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ      = 3'd4;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_A_START = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_A_END   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_B_START = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_B_END   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_C_START = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_C_END   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGES_IN_USE = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_THREAD_FILTER = 4'd7;

	// Commands handed from the classifier to the counter engine.
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_MARK,
		CMD_INC,
		CMD_DEC,
		CMD_SET,
		CMD_READ
	} cmd_kind_t;

	localparam int CMD_W = $bits(cmd_kind_t);

endpackage

/* rtl/core/ect_queue.sv */
module ect_queue import ect_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] dout
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	// Status flags and the word at the head of the queue.
	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign dout      = slots_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots hold payload only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= din;
		end
	end

endmodule

/* rtl/core/ect_front.sv */
module ect_front import ect_pkg::*; #(
	parameter int IDX_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [OP_W-1:0]      opcode,
	input  logic [ADDR_W-1:0]    address,
	input  logic [ADDR_W-1:0]    block_end,
	input  logic [ADDR_W-1:0]    thread_id,
	input  logic                 clear_done,
	input  logic                 queue_full,
	output logic                 cmd_push,
	output cmd_kind_t            cmd_kind,
	output logic [IDX_W-1:0]     cmd_idx
);

	// Configuration registers.
	logic [ADDR_W-1:0]   ra_start_q, ra_end_q;
	logic [ADDR_W-1:0]   rb_start_q, rb_end_q;
	logic [ADDR_W-1:0]   rc_start_q, rc_end_q;
	logic [RANGES_W-1:0] ranges_q;
	logic [ADDR_W-1:0]   filter_q;

	// Tracking state.
	logic [IDX_W-2:0]  last_loc_q;
	logic [ADDR_W-1:0] lb_start_q, lb_end_q;
	logic              lb_vld_q;
	logic [IDX_W-1:0]  undo_idx_q;
	logic              undo_vld_q;
	logic [ADDR_W-1:0] int_pc_q;
	logic              int_vld_q;

	// Next values computed for the word on the input.
	logic [IDX_W-2:0]  last_loc_nxt;
	logic              lb_vld_nxt;
	logic              undo_vld_nxt;
	logic              int_vld_nxt;
	logic              lb_load;
	logic              int_load;
	logic [ADDR_W-1:0] filter_nxt;

	logic              accept;
	logic [ADDR_W-1:0] hash_full;
	logic [IDX_W-1:0]  hash;
	logic [IDX_W-1:0]  edge_idx;
	logic              in_ranges;
	logic              filter_ok;

	function automatic logic in_span(
		input logic [ADDR_W-1:0] a,
		input logic [ADDR_W-1:0] lo,
		input logic [ADDR_W-1:0] hi
	);
		return (lo <= a) && (a < hi);
	endfunction

	assign s_tready = clear_done && !queue_full;
	assign accept   = s_tvalid && s_tready;
	assign cmd_push = accept;

	// Location hash of the block start and the edge index it forms.
	assign hash_full = (address >> 4) ^ (address << 8);
	assign hash      = hash_full[IDX_W-1:0];
	assign edge_idx  = hash ^ {1'b0, last_loc_q};

	// Range and thread checks, all in parallel.
	assign in_ranges = ((ranges_q >= 2'd1) && in_span(address, ra_start_q, ra_end_q)) ||
		((ranges_q >= 2'd2) && in_span(address, rb_start_q, rb_end_q)) ||
		((ranges_q >= 2'd3) && in_span(address, rc_start_q, rc_end_q));
	assign filter_ok = (filter_q == '0) || (filter_q == thread_id);

	// Classification of the word and its effect on the tracking state.
	always_comb begin
		last_loc_nxt = last_loc_q;
		lb_vld_nxt   = lb_vld_q;
		undo_vld_nxt = undo_vld_q;
		int_vld_nxt  = int_vld_q;
		lb_load      = 1'b0;
		int_load     = 1'b0;
		filter_nxt   = filter_q;
		cmd_kind     = CMD_NONE;
		cmd_idx      = '0;
		case (opcode)
			OP_BLOCK: begin
				if (!filter_ok) begin
					cmd_kind = CMD_NONE;
				end else if (!in_ranges) begin
					undo_vld_nxt = 1'b0;
				end else if (int_vld_q && (int_pc_q == address)) begin
					int_vld_nxt = 1'b0;
				end else if (lb_vld_q && in_span(address, lb_start_q, lb_end_q)) begin
					cmd_kind = CMD_NONE;
				end else begin
					lb_load      = 1'b1;
					lb_vld_nxt   = 1'b1;
					undo_vld_nxt = 1'b1;
					last_loc_nxt = hash[IDX_W-1:1];
					cmd_kind     = CMD_INC;
					cmd_idx      = edge_idx;
				end
			end
			OP_CANCEL: begin
				if (undo_vld_q) begin
					undo_vld_nxt = 1'b0;
					lb_vld_nxt   = 1'b0;
					cmd_kind     = CMD_DEC;
					cmd_idx      = undo_idx_q;
				end
			end
			OP_INTERRUPT: begin
				if (in_ranges) begin
					int_load    = 1'b1;
					int_vld_nxt = 1'b1;
					cmd_kind    = CMD_MARK;
				end
			end
			OP_NEW_ITER: begin
				last_loc_nxt = '0;
				lb_vld_nxt   = 1'b0;
				undo_vld_nxt = 1'b0;
				int_vld_nxt  = 1'b0;
				filter_nxt   = FILTER_RESET;
				cmd_kind     = CMD_SET;
			end
			OP_READ: begin
				cmd_kind = CMD_READ;
				cmd_idx  = address[IDX_W-1:0];
			end
			default: begin
				cmd_kind = CMD_NONE;
			end
		endcase
	end

	// Register writes and tracking updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra_start_q <= '0;
			ra_end_q   <= '0;
			rb_start_q <= '0;
			rb_end_q   <= '0;
			rc_start_q <= '0;
			rc_end_q   <= '0;
			ranges_q   <= '0;
			filter_q   <= FILTER_RESET;
			last_loc_q <= '0;
			lb_start_q <= '0;
			lb_end_q   <= '0;
			lb_vld_q   <= 1'b0;
			undo_idx_q <= '0;
			undo_vld_q <= 1'b0;
			int_pc_q   <= '0;
			int_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RANGE_A_START: ra_start_q <= cfg_wdata;
					CFG_RANGE_A_END:   ra_end_q   <= cfg_wdata;
					CFG_RANGE_B_START: rb_start_q <= cfg_wdata;
					CFG_RANGE_B_END:   rb_end_q   <= cfg_wdata;
					CFG_RANGE_C_START: rc_start_q <= cfg_wdata;
					CFG_RANGE_C_END:   rc_end_q   <= cfg_wdata;
					CFG_RANGES_IN_USE: ranges_q   <= cfg_wdata[RANGES_W-1:0];
					CFG_THREAD_FILTER: filter_q   <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (accept) begin
				last_loc_q <= last_loc_nxt;
				lb_vld_q   <= lb_vld_nxt;
				undo_vld_q <= undo_vld_nxt;
				int_vld_q  <= int_vld_nxt;
				filter_q   <= filter_nxt;
				if (lb_load) begin
					lb_start_q <= address;
					lb_end_q   <= block_end;
					undo_idx_q <= edge_idx;
				end
				if (int_load) begin
					int_pc_q <= address;
				end
			end
		end
	end

endmodule

/* rtl/core/ect_back.sv */
module ect_back import ect_pkg::*; #(
	parameter int MAP_ENTRIES = 65536
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  cmd_kind_t                    cmd_kind,
	input  logic [$clog2(MAP_ENTRIES)-1:0] cmd_idx,
	output logic                         cmd_pop,
	output logic                         clear_done,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic                         out_accepted,
	output logic [INDEX_OUT_W-1:0]       out_index,
	output logic [COUNT_W-1:0]           out_count
);

	localparam int IDX_W = $clog2(MAP_ENTRIES);

	logic [COUNT_W-1:0] mem_q [MAP_ENTRIES];

	// Clearing pass after reset.
	logic [IDX_W-1:0] clr_idx_q;
	logic             clr_busy_q;

	// Read stage: command and registered counter value.
	logic               vld_s1;
	cmd_kind_t          kind_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [COUNT_W-1:0] rd_s1;

	// Last counter write, for a read issued in the same cycle.
	logic               fwd_vld_q;
	logic [IDX_W-1:0]   fwd_idx_q;
	logic [COUNT_W-1:0] fwd_val_q;

	// Output register.
	logic                   out_vld_q;
	logic                   out_acc_q;
	logic [INDEX_OUT_W-1:0] out_idx_q;
	logic [COUNT_W-1:0]     out_cnt_q;

	logic               space;
	logic               advance;
	logic [COUNT_W-1:0] old_cnt;
	logic [COUNT_W-1:0] new_cnt;
	logic               upd_we;
	logic               res_acc;
	logic [IDX_W-1:0]   res_idx;
	logic [COUNT_W-1:0] res_cnt;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	logic [COUNT_W-1:0] mem_wd;

	assign clear_done = !clr_busy_q;
	assign space      = !out_vld_q || m_tready;
	assign advance    = !vld_s1 || space;
	assign cmd_pop    = advance && cmd_valid;

	// Counter value seen by the command in the read stage.
	assign old_cnt = (fwd_vld_q && (fwd_idx_q == idx_s1)) ? fwd_val_q : rd_s1;

	// Update and result of the command in the read stage.
	always_comb begin
		new_cnt = old_cnt;
		upd_we  = 1'b0;
		res_acc = 1'b0;
		res_idx = '0;
		res_cnt = '0;
		case (kind_s1)
			CMD_MARK: begin
				res_acc = 1'b1;
			end
			CMD_INC: begin
				new_cnt = old_cnt + 1'b1;
				upd_we  = 1'b1;
				res_acc = 1'b1;
				res_idx = idx_s1;
				res_cnt = new_cnt;
			end
			CMD_DEC: begin
				new_cnt = old_cnt - 1'b1;
				upd_we  = 1'b1;
				res_acc = 1'b1;
				res_idx = idx_s1;
				res_cnt = new_cnt;
			end
			CMD_SET: begin
				new_cnt = COUNT_W'(1);
				upd_we  = 1'b1;
				res_acc = 1'b1;
				res_idx = idx_s1;
				res_cnt = new_cnt;
			end
			CMD_READ: begin
				res_acc = 1'b1;
				res_idx = idx_s1;
				res_cnt = old_cnt;
			end
			default: begin
				res_acc = 1'b0;
			end
		endcase
	end

	// The write port serves the clearing pass, then counter updates.
	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_idx_q;
			mem_wd = '0;
		end else begin
			mem_we = vld_s1 && space && upd_we;
			mem_wa = idx_s1;
			mem_wd = new_cnt;
		end
	end

	// Counter memory with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (cmd_pop) begin
			rd_s1 <= mem_q[cmd_idx];
		end
	end

	// Control of the clearing pass, the read stage and the output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
			vld_s1     <= 1'b0;
			fwd_vld_q  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == IDX_W'(MAP_ENTRIES - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (advance) begin
				vld_s1 <= cmd_valid;
			end
			if (vld_s1 && space && upd_we) begin
				fwd_vld_q <= 1'b1;
			end
			if (space) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			kind_s1 <= cmd_kind;
			idx_s1  <= cmd_idx;
		end
		if (vld_s1 && space && upd_we) begin
			fwd_idx_q <= idx_s1;
			fwd_val_q <= new_cnt;
		end
		if (vld_s1 && space) begin
			out_acc_q <= res_acc;
			out_idx_q <= INDEX_OUT_W'(res_idx);
			out_cnt_q <= res_cnt;
		end
	end

	assign m_tvalid     = out_vld_q;
	assign out_accepted = out_acc_q;
	assign out_index    = out_idx_q;
	assign out_count    = out_cnt_q;

endmodule

/* rtl/core/edge_coverage_bitmap_tracer.sv */
// Edge coverage tracer: each word on the slave stream carries one operation
// (basic block, cancel, interrupt, new iteration or counter read) and gives
// exactly one word on the master stream. The block sustains one word per
// clock cycle while the master side takes its words: a classifier settles the
// range, thread, interrupt and last-block checks combinationally and updates
// the tracking registers as each word is accepted, and a counter engine behind
// a four-word queue does the 8-bit read-modify-write on a single-write-port
// memory with a registered read and a one-entry bypass. A result word passes
// the queue, the read stage and the output register before it is offered on
// the master side. After reset the counter memory is cleared one entry a
// cycle and s_tready stays low until it is done; register writes are taken
// throughout. Registers may be written only while no word is in flight.
module edge_coverage_bitmap_tracer import ect_pkg::*; #(
	parameter int MAP_ENTRIES = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// s_tdata fields from bit 0: address[63:0], block_end[127:64], thread_id[191:128]
	input  logic [3*ADDR_W-1:0]  s_tdata,
	// s_tuser fields from bit 0: opcode[2:0]
	input  logic [OP_W-1:0]      s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// m_tdata fields from bit 0: entry_index[15:0], entry_count[23:16]
	output logic [INDEX_OUT_W+COUNT_W-1:0] m_tdata,
	// m_tuser fields from bit 0: accepted[0]
	output logic                 m_tuser
);

	localparam int IDX_W       = $clog2(MAP_ENTRIES);
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_W         = CMD_W + IDX_W;

	logic               clear_done;
	logic               queue_full;
	logic               cmd_push;
	cmd_kind_t          push_kind;
	logic [IDX_W-1:0]   push_idx;
	logic [Q_W-1:0]     q_dout;
	logic               q_not_empty;
	logic               q_pop;
	logic               out_accepted;
	logic [INDEX_OUT_W-1:0] out_index;
	logic [COUNT_W-1:0]     out_count;

	// Classifier and tracking registers.
	ect_front #(
		.IDX_W(IDX_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.opcode    (s_tuser),
		.address   (s_tdata[ADDR_W-1:0]),
		.block_end (s_tdata[2*ADDR_W-1:ADDR_W]),
		.thread_id (s_tdata[3*ADDR_W-1:2*ADDR_W]),
		.clear_done(clear_done),
		.queue_full(queue_full),
		.cmd_push  (cmd_push),
		.cmd_kind  (push_kind),
		.cmd_idx   (push_idx)
	);

	// Command queue between the classifier and the counter engine.
	ect_queue #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.din      ({push_kind, push_idx}),
		.full     (queue_full),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.dout     (q_dout)
	);

	// Counter engine and output register.
	ect_back #(
		.MAP_ENTRIES(MAP_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_not_empty),
		.cmd_kind    (cmd_kind_t'(q_dout[Q_W-1:IDX_W])),
		.cmd_idx     (q_dout[IDX_W-1:0]),
		.cmd_pop     (q_pop),
		.clear_done  (clear_done),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.out_accepted(out_accepted),
		.out_index   (out_index),
		.out_count   (out_count)
	);

	assign m_tdata = {out_count, out_index};
	assign m_tuser = out_accepted;

endmodule

/* test/edge_coverage_bitmap_tracer_tb.sv */
module edge_coverage_bitmap_tracer_tb import ect_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam real CLK_PERIOD   = 12.0;
	localparam int  RESET_CYCLES = 4;
	localparam int  MAP_ENTRIES  = 65536;
	localparam int  CYCLE_LIMIT  = 1_000_000;
	localparam int  DRAIN_CYCLES = 12;
	localparam int  RANDOM_WORDS = 30;
	localparam int  WRAP_RUN     = 256;
	localparam int  LONG_HOLD    = 400;

	// Opcodes and register indexes that the block leaves without effect.
	localparam logic [OP_W-1:0]      OP_SPARE_FIRST  = 3'd5;
	localparam logic [OP_W-1:0]      OP_SPARE_LAST   = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 4'd8;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 4'd15;

	localparam logic [ADDR_W-1:0] ALL_ONES = '1;
	// Hot address for the counter wrap run and the index it settles on.
	localparam logic [ADDR_W-1:0]      HOT_PC  = 64'h2000;
	localparam logic [INDEX_OUT_W-1:0] HOT_IDX = 16'h0300;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] bend;
		logic [ADDR_W-1:0] tid;
	} trace_op_t;

	typedef struct packed {
		logic                   accepted;
		logic [INDEX_OUT_W-1:0] index;
		logic [COUNT_W-1:0]     count;
	} hit_report_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]          cfg_index = '0;
	logic [ADDR_W-1:0]             cfg_wdata = '0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [3*ADDR_W-1:0]           s_tdata   = '0;
	logic [OP_W-1:0]               s_tuser   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [INDEX_OUT_W+COUNT_W-1:0] m_tdata;
	logic                          m_tuser;

	// Words waiting to be sent and reports still owed by the block.
	trace_op_t   op_backlog[$];
	hit_report_t due_reports[$];

	// Tracer state as the checker sees it.
	logic [ADDR_W-1:0]      span_lo [3];
	logic [ADDR_W-1:0]      span_hi [3];
	int                     spans_live;
	logic [ADDR_W-1:0]      thread_sel;
	logic [COUNT_W-1:0]     hit_model [MAP_ENTRIES];
	logic [INDEX_OUT_W-1:0] last_loc;
	logic [ADDR_W-1:0]      last_lo;
	logic [ADDR_W-1:0]      last_hi;
	logic                   last_ok;
	logic [INDEX_OUT_W-1:0] undo_idx;
	logic                   undo_ok;
	logic [ADDR_W-1:0]      irq_pc;
	logic                   irq_ok;

	// What the stimulus side believes is configured, used to aim addresses.
	logic [ADDR_W-1:0] sv_lo [3];
	logic [ADDR_W-1:0] sv_hi [3];
	int                sv_n;
	logic [ADDR_W-1:0] sv_filter;
	logic [ADDR_W-1:0] sv_last_addr;
	logic [ADDR_W-1:0] sv_last_end;
	logic [ADDR_W-1:0] sv_prev_addr;
	logic [ADDR_W-1:0] sv_irq_pc;
	logic              sv_irq_next;

	int          send_gap;
	int          tx_calm;
	int          rx_calm;
	int          hold_left;
	bit          long_hold_done;
	int          words_sent;
	int          reports_checked;
	int          reports_accepted;
	int          error_count;
	int          cycle_count;
	trace_op_t   next_word;
	hit_report_t want;
	hit_report_t got;

	edge_coverage_bitmap_tracer #(
		.MAP_ENTRIES(MAP_ENTRIES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	function automatic logic [ADDR_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [INDEX_OUT_W-1:0] edge_hash(input logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] mixed;
		mixed = (a >> 4) ^ (a << 8);
		return mixed[INDEX_OUT_W-1:0];
	endfunction

	// Idle length for either side: mostly none, some short, a few long, and
	// now and then a calm stretch with no idling at all.
	function automatic int draw_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(40, 120);
			return 0;
		end
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic bit in_traced(input logic [ADDR_W-1:0] a);
		for (int i = 0; i < spans_live; i++) begin
			if (span_lo[i] <= a && a < span_hi[i])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Applies one word to the tracer state and returns the report it owes.
	function automatic hit_report_t trace_step(input logic [OP_W-1:0] op,
			input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] bend,
			input logic [ADDR_W-1:0] tid);
		hit_report_t            rep;
		logic [INDEX_OUT_W-1:0] h;
		logic [INDEX_OUT_W-1:0] idx;
		rep = '0;
		case (op)
			OP_BLOCK: begin
				if (thread_sel != '0 && thread_sel != tid) begin
					// Other thread: nothing changes.
				end else if (!in_traced(addr)) begin
					undo_ok = 1'b0;
				end else if (irq_ok && irq_pc == addr) begin
					irq_ok = 1'b0;
				end else if (last_ok && last_lo <= addr && addr < last_hi) begin
					// Still inside the block just counted.
				end else begin
					last_lo = addr;
					last_hi = bend;
					last_ok = 1'b1;
					h = edge_hash(addr);
					idx = h ^ last_loc;
					hit_model[idx] = hit_model[idx] + 1'b1;
					undo_idx = idx;
					undo_ok = 1'b1;
					last_loc = h >> 1;
					rep.accepted = 1'b1;
					rep.index = idx;
					rep.count = hit_model[idx];
				end
			end
			OP_CANCEL: begin
				if (undo_ok) begin
					hit_model[undo_idx] = hit_model[undo_idx] - 1'b1;
					undo_ok = 1'b0;
					last_ok = 1'b0;
					rep.accepted = 1'b1;
					rep.index = undo_idx;
					rep.count = hit_model[undo_idx];
				end
			end
			OP_INTERRUPT: begin
				if (in_traced(addr)) begin
					irq_pc = addr;
					irq_ok = 1'b1;
					rep.accepted = 1'b1;
				end
			end
			OP_NEW_ITER: begin
				hit_model[0] = COUNT_W'(1);
				last_loc = '0;
				last_ok = 1'b0;
				undo_ok = 1'b0;
				irq_ok = 1'b0;
				thread_sel = FILTER_RESET;
				rep.accepted = 1'b1;
				rep.count = COUNT_W'(1);
			end
			OP_READ: begin
				idx = addr[INDEX_OUT_W-1:0];
				rep.accepted = 1'b1;
				rep.index = idx;
				rep.count = hit_model[idx];
			end
			default: begin
			end
		endcase
		return rep;
	endfunction

	// A start address inside one of the configured ranges, often near its start.
	function automatic logic [ADDR_W-1:0] pick_in_range();
		int                i;
		logic [ADDR_W-1:0] span;
		if (sv_n == 0)
			return rand64();
		i = $urandom_range(0, sv_n - 1);
		if (sv_hi[i] <= sv_lo[i])
			return rand64();
		span = sv_hi[i] - sv_lo[i];
		if ($urandom_range(0, 99) < 60 && span > 512)
			span = 512;
		return sv_lo[i] + rand64() % span;
	endfunction

	// One random word, mostly well-formed traces with some noise mixed in.
	function automatic trace_op_t random_word();
		trace_op_t w;
		int        r;
		int        s;
		int        i;
		w.addr = rand64();
		w.bend = rand64();
		w.tid = rand64();
		r = $urandom_range(0, 99);
		if (r < 68) begin
			w.op = OP_BLOCK;
			if (sv_filter != '0 && $urandom_range(0, 99) < 85)
				w.tid = sv_filter;
			s = $urandom_range(0, 99);
			if (sv_irq_next) begin
				w.addr = sv_irq_pc;
				sv_irq_next = 1'b0;
			end else if (s < 15 && sv_last_end > sv_last_addr) begin
				w.addr = sv_last_addr + rand64() % (sv_last_end - sv_last_addr);
			end else if (s < 80) begin
				w.addr = pick_in_range();
			end else if (s < 88 && sv_n > 0) begin
				i = $urandom_range(0, sv_n - 1);
				w.addr = $urandom_range(0, 1) ? sv_hi[i] : sv_lo[i] - 1;
			end
			s = $urandom_range(0, 99);
			if (s < 60)
				w.bend = w.addr + $urandom_range(1, 48);
			else if (s < 75)
				w.bend = w.addr;
			sv_prev_addr = sv_last_addr;
			sv_last_addr = w.addr;
			sv_last_end = w.bend;
		end else if (r < 75) begin
			w.op = OP_CANCEL;
		end else if (r < 82) begin
			w.op = OP_INTERRUPT;
			if ($urandom_range(0, 99) < 80)
				w.addr = pick_in_range();
			sv_irq_pc = w.addr;
			sv_irq_next = ($urandom_range(0, 99) < 60);
		end else if (r < 84) begin
			w.op = OP_NEW_ITER;
			sv_filter = FILTER_RESET;
		end else if (r < 94) begin
			w.op = OP_READ;
			if ($urandom_range(0, 1))
				w.addr = {w.addr[ADDR_W-1:INDEX_OUT_W],
					edge_hash(sv_last_addr) ^ (edge_hash(sv_prev_addr) >> 1)};
		end else begin
			w.op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end
		return w;
	endfunction

	task automatic queue_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [ADDR_W-1:0] bend, input logic [ADDR_W-1:0] tid);
		trace_op_t w;
		w.op = op;
		w.addr = addr;
		w.bend = bend;
		w.tid = tid;
		op_backlog.push_back(w);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Writes every register and records the setting for the stimulus side.
	task automatic set_ranges(input logic [ADDR_W-1:0] a_lo, input logic [ADDR_W-1:0] a_hi,
			input logic [ADDR_W-1:0] b_lo, input logic [ADDR_W-1:0] b_hi,
			input logic [ADDR_W-1:0] c_lo, input logic [ADDR_W-1:0] c_hi,
			input logic [ADDR_W-1:0] n_raw, input logic [ADDR_W-1:0] filter);
		write_reg(CFG_RANGE_A_START, a_lo);
		write_reg(CFG_RANGE_A_END, a_hi);
		write_reg(CFG_RANGE_B_START, b_lo);
		write_reg(CFG_RANGE_B_END, b_hi);
		write_reg(CFG_RANGE_C_START, c_lo);
		write_reg(CFG_RANGE_C_END, c_hi);
		write_reg(CFG_RANGES_IN_USE, n_raw);
		write_reg(CFG_THREAD_FILTER, filter);
		sv_lo[0] = a_lo;
		sv_hi[0] = a_hi;
		sv_lo[1] = b_lo;
		sv_hi[1] = b_hi;
		sv_lo[2] = c_lo;
		sv_hi[2] = c_hi;
		sv_n = int'(n_raw[RANGES_W-1:0]);
		sv_filter = filter;
	endtask

	// Holds off until every word has been sent and every report has come.
	task automatic wait_idle();
		@(posedge clk);
		while (op_backlog.size() != 0 || s_tvalid || due_reports.size() != 0)
			@(posedge clk);
	endtask

	// Sender: takes register writes into the checker state, predicts the report
	// of each accepted word and offers the next word after a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap = 0;
			tx_calm = 0;
			words_sent = 0;
			for (int i = 0; i < 3; i++) begin
				span_lo[i] = '0;
				span_hi[i] = '0;
			end
			spans_live = 0;
			thread_sel = FILTER_RESET;
			for (int i = 0; i < MAP_ENTRIES; i++)
				hit_model[i] = '0;
			last_loc = '0;
			last_lo = '0;
			last_hi = '0;
			last_ok = 1'b0;
			undo_idx = '0;
			undo_ok = 1'b0;
			irq_pc = '0;
			irq_ok = 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_RANGE_A_START: span_lo[0] = cfg_wdata;
					CFG_RANGE_A_END:   span_hi[0] = cfg_wdata;
					CFG_RANGE_B_START: span_lo[1] = cfg_wdata;
					CFG_RANGE_B_END:   span_hi[1] = cfg_wdata;
					CFG_RANGE_C_START: span_lo[2] = cfg_wdata;
					CFG_RANGE_C_END:   span_hi[2] = cfg_wdata;
					CFG_RANGES_IN_USE: spans_live = int'(cfg_wdata[RANGES_W-1:0]);
					CFG_THREAD_FILTER: thread_sel = cfg_wdata;
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				due_reports.push_back(trace_step(s_tuser, s_tdata[ADDR_W-1:0],
					s_tdata[2*ADDR_W-1:ADDR_W], s_tdata[3*ADDR_W-1:2*ADDR_W]));
				words_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (op_backlog.size() != 0) begin
					next_word = op_backlog.pop_front();
					s_tdata <= {next_word.tid, next_word.bend, next_word.addr};
					s_tuser <= next_word.op;
					s_tvalid <= 1'b1;
					send_gap = draw_idle(tx_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result word against the oldest report owed and
	// stalls at random, once for a long stretch so that the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
			rx_calm = 0;
			long_hold_done = 1'b0;
			reports_checked = 0;
			reports_accepted = 0;
			error_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.accepted = m_tuser;
				got.index = m_tdata[INDEX_OUT_W-1:0];
				got.count = m_tdata[INDEX_OUT_W+COUNT_W-1:INDEX_OUT_W];
				if (due_reports.size() == 0) begin
					$error("result word with no report owed: accepted %0d index %0h count %0d",
						got.accepted, got.index, got.count);
					error_count++;
				end else begin
					want = due_reports.pop_front();
					if (got.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
						error_count++;
					end
					if (got.index !== want.index) begin
						$error("entry_index: expected %0h, got %0h", want.index, got.index);
						error_count++;
					end
					if (got.count !== want.count) begin
						$error("entry_count: expected %0d, got %0d", want.count, got.count);
						error_count++;
					end
					if (want.accepted)
						reports_accepted++;
				end
				reports_checked++;
			end
			if (reports_checked == 30 && !long_hold_done) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				hold_left = draw_idle(rx_calm);
				if (hold_left == 0) begin
					m_tready <= 1'b1;
				end else begin
					hold_left--;
					m_tready <= 1'b0;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("edge_coverage_bitmap_tracer_tb: FAIL");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		sv_n = 0;
		sv_filter = FILTER_RESET;
		sv_last_addr = '0;
		sv_last_end = '0;
		sv_prev_addr = '0;
		sv_irq_pc = '0;
		sv_irq_next = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: no range active and the default thread filter.
		queue_op(OP_BLOCK, '0, ALL_ONES, '0);
		queue_op(OP_BLOCK, '0, ALL_ONES, FILTER_RESET);
		queue_op(OP_INTERRUPT, '0, '0, FILTER_RESET);
		queue_op(OP_CANCEL, '0, '0, '0);
		queue_op(OP_READ, '0, '0, '0);
		queue_op(OP_READ, ALL_ONES, ALL_ONES, ALL_ONES);
		queue_op(OP_NEW_ITER, ALL_ONES, ALL_ONES, ALL_ONES);
		queue_op(OP_SPARE_FIRST, ALL_ONES, ALL_ONES, ALL_ONES);
		queue_op(OP_SPARE_FIRST + 3'd1, '0, '0, '0);
		queue_op(OP_SPARE_LAST, ALL_ONES, ALL_ONES, ALL_ONES);
		wait_idle();

		// Three ranges, the last one reversed; writes past the last register.
		set_ranges(64'h1000, 64'h9000, 64'hFFFF_FFFF_FFFF_0000, ALL_ONES,
			64'h5000_0000, 64'h4000_0000, ALL_ONES, '0);
		write_reg(CFG_SPARE_FIRST, rand64());
		write_reg(CFG_SPARE_LAST, ALL_ONES);

		// Counter wrap: one hot block counted until its entry rolls over to
		// zero, then a cancel takes it back round to the top.
		queue_op(OP_NEW_ITER, '0, '0, '0);
		queue_op(OP_BLOCK, HOT_PC, HOT_PC, FILTER_RESET);
		for (int k = 0; k < WRAP_RUN; k++)
			queue_op(OP_BLOCK, HOT_PC, 64'($urandom_range(0, 32'h2000)), FILTER_RESET);
		queue_op(OP_CANCEL, rand64(), rand64(), rand64());
		queue_op(OP_READ, {(ADDR_W-INDEX_OUT_W)'(rand64()), HOT_IDX}, '0, '0);
		wait_idle();

		// Drop order, last-block skip, cancels and interrupt consumption.
		write_reg(CFG_THREAD_FILTER, '0);
		queue_op(OP_BLOCK, 64'h1000, 64'h1040, rand64());
		queue_op(OP_BLOCK, 64'h1010, 64'h1020, rand64());
		queue_op(OP_CANCEL, '0, '0, '0);
		queue_op(OP_CANCEL, '0, '0, '0);
		queue_op(OP_BLOCK, 64'h1010, 64'h1020, rand64());
		queue_op(OP_BLOCK, 64'h9000, 64'h9010, rand64());
		queue_op(OP_CANCEL, '0, '0, '0);
		queue_op(OP_INTERRUPT, 64'h2000, '0, '0);
		queue_op(OP_BLOCK, 64'h2000, 64'h2010, rand64());
		queue_op(OP_BLOCK, 64'h2000, 64'h2010, rand64());
		queue_op(OP_BLOCK, ALL_ONES - 1, ALL_ONES, ALL_ONES);
		queue_op(OP_BLOCK, ALL_ONES, ALL_ONES, '0);
		queue_op(OP_BLOCK, 64'h4800_0000, 64'h4800_0010, rand64());
		queue_op(OP_BLOCK, 64'h0FFF, 64'h1000, rand64());
		queue_op(OP_INTERRUPT, 64'h7777_7777, '0, '0);
		queue_op(OP_READ, ALL_ONES, '0, '0);
		queue_op(OP_NEW_ITER, '0, '0, '0);
		queue_op(OP_BLOCK, 64'h3000, 64'h3100, '0);
		queue_op(OP_BLOCK, 64'h3000, 64'h3100, FILTER_RESET);
		queue_op(OP_READ, '0, '0, '0);
		wait_idle();

		// Random traffic under several settings.
		set_ranges(64'h1000, 64'h3000, 64'h8000_0000, 64'h8000_1000,
			64'hFFFF_FFFF_FFFF_F000, ALL_ONES, 64'd3, '0);
		for (int k = 0; k < RANDOM_WORDS; k++)
			op_backlog.push_back(random_word());
		wait_idle();

		set_ranges('0, ALL_ONES, '0, '0, '0, '0, 64'h5, 64'h1234_5678_9ABC_DEF0);
		for (int k = 0; k < RANDOM_WORDS; k++)
			op_backlog.push_back(random_word());
		wait_idle();

		set_ranges(64'h5000, 64'h5000, 64'h100, 64'h900, 64'h9000_0000, 64'h10,
			64'd2, ALL_ONES);
		for (int k = 0; k < RANDOM_WORDS; k++)
			op_backlog.push_back(random_word());
		wait_idle();

		begin
			logic [ADDR_W-1:0] lo_a;
			logic [ADDR_W-1:0] lo_b;
			logic [ADDR_W-1:0] lo_c;
			lo_a = rand64();
			lo_b = rand64();
			lo_c = rand64();
			set_ranges(lo_a, lo_a + $urandom, lo_b, lo_b + $urandom, lo_c, lo_c + rand64(),
				rand64(), '0);
		end
		for (int k = 0; k < RANDOM_WORDS; k++)
			op_backlog.push_back(random_word());
		wait_idle();

		// Range count written with only high bits set: nothing is traced.
		set_ranges('0, ALL_ONES, '0, ALL_ONES, '0, ALL_ONES, 64'hFFFF_FFFF_FFFF_FFFC, '0);
		queue_op(OP_BLOCK, rand64(), rand64(), rand64());
		queue_op(OP_INTERRUPT, rand64(), '0, '0);
		queue_op(OP_CANCEL, '0, '0, '0);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d words and checked %0d result words, %0d of them accepted.",
			words_sent, reports_checked, reports_accepted);
		$display("Covered range and thread drops, interrupts, cancels, counter wrap and reads.");
		if (error_count == 0 && due_reports.size() == 0) begin
			$display("edge_coverage_bitmap_tracer_tb: PASS");
		end else begin
			$display("edge_coverage_bitmap_tracer_tb: FAIL");
		end
		$finish;
	end

endmodule
